// ----- hdl/wrmm_pkg.sv -----
package wrmm_pkg;

  // store geometry (depth is a power of two so slot and position wrap by masking)
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // shared arithmetic unit width: signed 33-bit second difference times 1e6 plus usec term
  localparam int ALU_W = 54;

  // shift-add multiply by the microseconds-per-second constant
  localparam int             MUL_STEPS    = 20;
  localparam logic [19:0]    USEC_PER_SEC = 20'd1000000;

  // restoring divide of the look-back span by the ping interval
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // operation and result kind codes
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_MIN    = 2'd1;
  localparam logic [1:0] OP_MAX    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // register indexes and reset values
  localparam logic [1:0]  REG_PING_INTERVAL = 2'd0;
  localparam logic [1:0]  REG_BASE_WINDOW   = 2'd1;
  localparam logic [31:0] PING_RESET        = 32'd100000;
  localparam logic [8:0]  BASE_RESET        = 9'd100;

  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  // request to the entry store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ----- hdl/windowed_rtt_min_max_store.sv -----
// Windowed round-trip time store with minimum and maximum queries.
// Input stream (in_*): one request per item. in_tuser is the operation:
// record, minimum query or maximum query; the unused code is taken and dropped.
// A record computes the send-to-receive span in microseconds with a shared
// adder (20-step shift-add multiply by one million), clamps it to 32 bits,
// writes the slot and makes it the newest.
// A minimum query scans back from the newest slot over base_window_entries
// entries; a maximum query first divides timeframe_us by ping_interval_us with
// a 32-step restoring divide on the same adder, skipped if ping_interval_us is
// zero. Both scans read one entry per cycle from the store's registered port,
// over at most 256 entries. in_tready is high only while no request is in
// work. The result goes to an output register; the next request is taken
// while it waits, but a finished request holds in work until out_tready
// frees that register. Config port (cfg_*): index 0 ping interval, index 1
// base window, always ready; the user must see that it is written only while
// idle, which the block does not enforce. Reset clears the store (valid bits),
// the newest slot, the output and loads the default configuration.
module windowed_rtt_min_max_store
  import wrmm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot_id[7:0], sent_sec[39:8], sent_usec[59:40], now_sec[91:60],
  // now_usec[111:92], timeframe_us[143:112]
  input  logic [143:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_value[31:0]
  output logic [31:0]  out_tdata,
  // result_kind[1:0]
  output logic [1:0]   out_tuser
);

  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_y;
  mem_req_t         mem_req;
  logic [31:0]      rd_data;

  wrmm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .alu_req    (alu_req),
    .alu_y      (alu_y),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  wrmm_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  wrmm_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ----- hdl/wrmm_alu.sv -----
module wrmm_alu
  import wrmm_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] y
);

  // one adder, b inverted with carry in for subtraction
  assign y = req.a + (req.b ^ {ALU_W{req.sub}}) + {{(ALU_W-1){1'b0}}, req.sub};

endmodule

// ----- hdl/wrmm_store.sv -----
module wrmm_store
  import wrmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);

  logic [31:0]            mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [31:0]            rd_data_r;

  // entry array, no reset
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // valid bits stand in for the all-zero reset of the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // registered read, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.rd_addr] ? mem[req.rd_addr] : 32'd0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/wrmm_seq.sv -----
module wrmm_seq
  import wrmm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [143:0]     in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output alu_req_t         alu_req,
  input  logic [ALU_W-1:0] alu_y,
  output mem_req_t         mem_req,
  input  logic [31:0]      rd_data
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SEC    = 10'b00_0000_0010,
    S_MUL    = 10'b00_0000_0100,
    S_UADD   = 10'b00_0000_1000,
    S_USUB   = 10'b00_0001_0000,
    S_CLAMP  = 10'b00_0010_0000,
    S_DIV    = 10'b00_0100_0000,
    S_DIVEND = 10'b00_1000_0000,
    S_SCAN   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [31:0]       ping_r;
  logic [8:0]        base_r;
  logic [ADDR_W-1:0] newest_r;
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] slot_r;
  logic [19:0]       sent_usec_r, now_usec_r;
  logic [ALU_W-1:0]  acc_r, m_r;
  logic [31:0]       quo_r;
  logic [STEP_W-1:0] step_r;
  logic [ADDR_W-1:0] pos_r;
  logic [CNT_W-1:0]  left_r;
  logic              pend_r;
  logic [31:0]       res_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;
  logic [1:0]        out_kind_r;

  logic              in_acc;
  logic [1:0]        in_op;
  logic [CNT_W-1:0]  min_cnt, max_cnt;
  logic [32:0]       div_sh;
  logic [31:0]       clamp_val;
  logic              is_less, scan_upd, out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign cfg_ready = 1'b1;

  // window counts saturate at the store depth
  assign min_cnt = (32'(base_r) > 32'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : CNT_W'(base_r);
  assign max_cnt = (quo_r > 32'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : CNT_W'(quo_r);

  // remainder shifted with the next dividend bit
  assign div_sh = {acc_r[31:0], quo_r[31]};

  // clamp of the signed microsecond total
  always_comb begin
    if (acc_r[ALU_W-1]) begin
      clamp_val = 32'd0;
    end else if (|acc_r[ALU_W-2:32]) begin
      clamp_val = ALL_ONES32;
    end else begin
      clamp_val = acc_r[31:0];
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_SEC: begin
        alu_req.a   = m_r;
        alu_req.b   = acc_r;
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = acc_r;
        alu_req.b = m_r;
      end
      S_UADD: begin
        alu_req.a = acc_r;
        alu_req.b = ALU_W'(now_usec_r);
      end
      S_USUB: begin
        alu_req.a   = acc_r;
        alu_req.b   = ALU_W'(sent_usec_r);
        alu_req.sub = 1'b1;
      end
      S_DIV: begin
        alu_req.a   = ALU_W'(div_sh);
        alu_req.b   = ALU_W'(ping_r);
        alu_req.sub = 1'b1;
      end
      S_SCAN: begin
        alu_req.sub = 1'b1;
        if (op_r == OP_MIN) begin
          alu_req.a = ALU_W'(rd_data);
          alu_req.b = ALU_W'(acc_r[31:0]);
        end else begin
          alu_req.a = ALU_W'(acc_r[31:0]);
          alu_req.b = ALU_W'(rd_data);
        end
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // scan compare: borrow means first operand below second
  assign is_less  = alu_y[ALU_W-1];
  assign scan_upd = (op_r == OP_MIN) ? (is_less && (rd_data != 32'd0)) : is_less;

  // store requests
  always_comb begin
    mem_req         = '0;
    mem_req.wr_en   = (state_r == S_CLAMP);
    mem_req.wr_addr = slot_r;
    mem_req.wr_data = clamp_val;
    mem_req.rd_en   = (state_r == S_SCAN) && (left_r != '0);
    mem_req.rd_addr = pos_r;
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_RECORD: state_nxt = S_SEC;
            OP_MIN:    state_nxt = S_SCAN;
            OP_MAX:    state_nxt = (ping_r == 32'd0) ? S_SCAN : S_DIV;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEC:    state_nxt = S_MUL;
      S_MUL:    state_nxt = (step_r == STEP_W'(MUL_STEPS - 1)) ? S_UADD : S_MUL;
      S_UADD:   state_nxt = S_USUB;
      S_USUB:   state_nxt = S_CLAMP;
      S_CLAMP:  state_nxt = S_DONE;
      S_DIV:    state_nxt = (step_r == STEP_W'(DIV_STEPS - 1)) ? S_DIVEND : S_DIV;
      S_DIVEND: state_nxt = S_SCAN;
      S_SCAN:   state_nxt = ((left_r == '0) && !pend_r) ? S_DONE : S_SCAN;
      S_DONE:   state_nxt = out_load ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ping_r      <= PING_RESET;
      base_r      <= BASE_RESET;
      newest_r    <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PING_INTERVAL: ping_r <= cfg_data;
          REG_BASE_WINDOW:   base_r <= cfg_data[8:0];
          default:           ;
        endcase
      end
      if (state_r == S_CLAMP) begin
        newest_r <= slot_r;
      end
      if (state_r == S_SCAN) begin
        pend_r <= (left_r != '0);
      end else begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r        <= in_op;
          slot_r      <= ADDR_W'(in_tdata[7:0] % STORE_DEPTH);
          sent_usec_r <= in_tdata[59:40];
          now_usec_r  <= in_tdata[111:92];
          step_r      <= '0;
          pos_r       <= newest_r;
          case (in_op)
            OP_RECORD: begin
              acc_r <= ALU_W'(in_tdata[39:8]);
              m_r   <= ALU_W'(in_tdata[91:60]);
            end
            OP_MIN: begin
              acc_r  <= ALU_W'(ALL_ONES32);
              left_r <= min_cnt;
            end
            default: begin
              acc_r  <= '0;
              quo_r  <= in_tdata[143:112];
              left_r <= CNT_W'(STORE_DEPTH);
            end
          endcase
        end
      end
      S_SEC: begin
        m_r   <= alu_y;
        acc_r <= '0;
      end
      S_MUL: begin
        if (USEC_PER_SEC[step_r]) begin
          acc_r <= alu_y;
        end
        m_r    <= {m_r[ALU_W-2:0], 1'b0};
        step_r <= step_r + STEP_W'(1);
      end
      S_UADD, S_USUB: begin
        acc_r <= alu_y;
      end
      S_CLAMP: begin
        res_r <= clamp_val;
      end
      S_DIV: begin
        acc_r  <= is_less ? ALU_W'(div_sh) : alu_y;
        quo_r  <= {quo_r[30:0], ~is_less};
        step_r <= step_r + STEP_W'(1);
      end
      S_DIVEND: begin
        acc_r  <= '0;
        left_r <= max_cnt;
        pos_r  <= newest_r;
      end
      S_SCAN: begin
        if (left_r != '0) begin
          pos_r  <= (pos_r == '0) ? ADDR_W'(STORE_DEPTH - 1) : pos_r - ADDR_W'(1);
          left_r <= left_r - CNT_W'(1);
        end
        if (pend_r && scan_upd) begin
          acc_r <= ALU_W'(rd_data);
        end
        res_r <= acc_r[31:0];
      end
      S_DONE: begin
        if (out_load) begin
          out_data_r <= res_r;
          out_kind_r <= op_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

// ----- hdl/wrmm_checker.sv -----
module wrmm_checker
  import wrmm_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [1:0]   out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // results only carry a real kind
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == OP_RECORD || out_tuser == OP_MIN || out_tuser == OP_MAX))
    else $error("result kind out of range");

  // a real request keeps the block busy the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != OP_UNUSED |=> !in_tready)
    else $error("ready while a request is in work");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind windowed_rtt_min_max_store wrmm_checker u_wrmm_checker (.*);

// ----- bench/windowed_rtt_min_max_store_tb.sv -----
`timescale 1ns / 100ps

module windowed_rtt_min_max_store_tb;
  import wrmm_pkg::*;

  localparam int     CYCLE_LIMIT    = 3_000_000;
  localparam int     SETTLE_CYCLES  = 320;
  localparam int     LONG_HOLD      = 1500;
  localparam int     PHASE_ITEMS    = 240;
  localparam int     PHASE_COUNT    = 6;
  localparam longint MICROS_PER_SEC = 1000000;
  // register index with no register behind it
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // request fields, slot_id in the lowest bits
  typedef struct packed {
    logic [31:0] timeframe_us;
    logic [19:0] now_usec;
    logic [31:0] now_sec;
    logic [19:0] sent_usec;
    logic [31:0] sent_sec;
    logic [7:0]  slot_id;
  } ping_request_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  kind;
  } rtt_answer_t;

  // mirror of the rtt store plus the queue of answers still owed by the block
  class rtt_window_checker;
    logic [31:0]       rtt_copy [STORE_DEPTH];
    logic [ADDR_W-1:0] newest;
    logic [31:0]       ping_interval;
    logic [8:0]        base_window;
    rtt_answer_t       expected_answers [$];
    int                mismatches;

    function new();
      foreach (rtt_copy[i]) rtt_copy[i] = '0;
      newest        = '0;
      ping_interval = PING_RESET;
      base_window   = BASE_RESET;
      mismatches    = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] data);
      if (index == REG_PING_INTERVAL) ping_interval = data;
      else if (index == REG_BASE_WINDOW) base_window = data[8:0];
    endfunction

    // receive minus send time in microseconds, clamped to 0 .. 2^32-1
    function logic [31:0] round_trip_us(ping_request_t r);
      longint sec_diff, usec_diff, total;
      sec_diff  = longint'({32'd0, r.now_sec}) - longint'({32'd0, r.sent_sec});
      usec_diff = longint'({44'd0, r.now_usec}) - longint'({44'd0, r.sent_usec});
      total     = sec_diff * MICROS_PER_SEC + usec_diff;
      if (total < 0) return '0;
      if (total > longint'({32'd0, ALL_ONES32})) return ALL_ONES32;
      return total[31:0];
    endfunction

    // walk back from the newest slot over count entries
    function logic [31:0] scan_back(longint unsigned count, bit want_min);
      logic [31:0]       best;
      logic [31:0]       v;
      logic [ADDR_W-1:0] pos;
      best = want_min ? ALL_ONES32 : '0;
      pos  = newest;
      if (count > 64'(STORE_DEPTH)) count = 64'(STORE_DEPTH);
      for (longint unsigned k = 0; k < count; k++) begin
        v = rtt_copy[pos];
        if (want_min) begin
          if (v != 0 && v < best) best = v;
        end else if (v > best) begin
          best = v;
        end
        pos = pos - 1'b1;
      end
      return best;
    endfunction

    function void note_request(logic [1:0] op, ping_request_t r);
      rtt_answer_t ans;
      ans.kind = op;
      case (op)
        OP_RECORD: begin
          ans.value = round_trip_us(r);
          rtt_copy[r.slot_id[ADDR_W-1:0]] = ans.value;
          newest = r.slot_id[ADDR_W-1:0];
        end
        OP_MIN: ans.value = scan_back(64'(base_window), 1'b1);
        OP_MAX: begin
          if (ping_interval == 0) ans.value = scan_back(64'(STORE_DEPTH), 1'b0);
          else ans.value = scan_back(64'(r.timeframe_us / ping_interval), 1'b0);
        end
        default: return;
      endcase
      expected_answers.push_back(ans);
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] kind);
      rtt_answer_t want;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result value=%0d kind=%0d", $realtime, value, kind);
        return;
      end
      want = expected_answers.pop_front();
      if (value !== want.value || kind !== want.kind) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch: expected value=%0d kind=%0d, got value=%0d kind=%0d",
                   $realtime, want.value, want.kind, value, kind);
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  ping_request_t in_tdata = '0;
  logic [1:0]    in_tuser = OP_RECORD;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = REG_PING_INTERVAL;
  logic [31:0]   cfg_data = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [31:0]   out_tdata;
  logic [1:0]    out_tuser;

  rtt_window_checker checker_sb;

  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 63;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  logic [7:0]  next_slot = '0;
  logic [31:0] clock_sec = '0;

  windowed_rtt_min_max_store DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off whenever the token moves
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) checker_sb.check_result(out_tdata, out_tuser);
  end

  // run timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // offer one request, with a random gap first, and wait for it to be taken
  task automatic send_request(input logic [1:0] op, input ping_request_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    checker_sb.note_request(op, r);
  endtask

  // stop offering, let every owed answer arrive, then let the block settle
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (checker_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    checker_sb.write_register(index, data);
  endtask

  task automatic set_config(input logic [31:0] ping, input logic [31:0] base,
                            input bit touch_unmapped);
    write_register(REG_PING_INTERVAL, ping);
    write_register(REG_BASE_WINDOW, base);
    if (touch_unmapped) write_register(REG_UNMAPPED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic ping_request_t stamp_pair(logic [7:0] slot, logic [31:0] ss,
                                               logic [19:0] su, logic [31:0] ns,
                                               logic [19:0] nu, logic [31:0] tf);
    ping_request_t r;
    r.slot_id      = slot;
    r.sent_sec     = ss;
    r.sent_usec    = su;
    r.now_sec      = ns;
    r.now_usec     = nu;
    r.timeframe_us = tf;
    return r;
  endfunction

  // random request: mostly well-formed pings on advancing slots, some noise
  task automatic random_request(output logic [1:0] op, output ping_request_t r);
    int unsigned     roll;
    longint unsigned stamp, span, k, tf, ping;
    roll = $urandom_range(99);
    r.slot_id      = 8'($urandom);
    r.sent_sec     = $urandom;
    r.sent_usec    = 20'($urandom);
    r.now_sec      = $urandom;
    r.now_usec     = 20'($urandom);
    r.timeframe_us = $urandom;
    if (roll < 55) begin
      op = OP_RECORD;
      if ($urandom_range(99) < 85) begin
        r.slot_id = ($urandom_range(99) < 90) ? next_slot : 8'($urandom);
        next_slot = r.slot_id + 1'b1;
        clock_sec = clock_sec + $urandom_range(0, 3);
        r.sent_sec  = clock_sec;
        r.sent_usec = 20'($urandom_range(0, 999999));
        case ($urandom_range(9))
          0:       span = 64'd0;
          1, 2:    span = 64'($urandom_range(0, 5000000));
          default: span = 64'($urandom_range(1, 300000));
        endcase
        stamp = 64'(r.sent_sec);
        stamp = stamp * MICROS_PER_SEC + 64'(r.sent_usec) + span;
        r.now_sec  = 32'(stamp / MICROS_PER_SEC);
        r.now_usec = 20'(stamp % MICROS_PER_SEC);
      end
    end else if (roll < 75) begin
      op = OP_MIN;
    end else if (roll < 95) begin
      op = OP_MAX;
      // look-back spans mostly a few ping intervals long
      ping = 64'(checker_sb.ping_interval);
      roll = $urandom_range(9);
      if (roll >= 3) begin
        k  = (roll < 5) ? 64'($urandom_range(0, 300)) : 64'($urandom_range(0, 12));
        tf = k * ping + ((ping > 1) ? 64'($urandom_range(0, 32'(ping - 1))) : 64'd0);
        r.timeframe_us = (tf > 64'(ALL_ONES32)) ? 32'($urandom) : tf[31:0];
      end
    end else begin
      op = OP_UNUSED;
    end
  endtask

  initial begin
    logic [1:0]    op;
    ping_request_t req;
    int            issued;
    checker_sb = new();
    clock_sec  = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, timestamp extremes, clamps and window edges
    send_request(OP_MIN,    stamp_pair(8'd0, 0, 0, 0, 0, 0));
    send_request(OP_MAX,    stamp_pair(8'd0, 0, 0, 0, 0, ALL_ONES32));
    send_request(OP_UNUSED, '1);
    send_request(OP_RECORD, stamp_pair(8'd0, 0, 0, 0, 0, 0));
    send_request(OP_RECORD, stamp_pair(8'd255, 5, 999999, 6, 0, 0));
    send_request(OP_RECORD, stamp_pair(8'd1, 10, 0, 9, 999999, 0));
    send_request(OP_RECORD, stamp_pair(8'd2, 0, 0, ALL_ONES32, 20'hFFFFF, 0));
    send_request(OP_RECORD, stamp_pair(8'd3, 0, 0, 4294, 967295, 0));
    send_request(OP_RECORD, stamp_pair(8'd4, 0, 0, 4294, 967296, 0));
    send_request(OP_RECORD, stamp_pair(8'd5, 100, 20'hFFFFF, 101, 0, 0));
    send_request(OP_RECORD, stamp_pair(8'd6, 100, 0, 100, 20'hFFFFF, 0));
    send_request(OP_RECORD, stamp_pair(8'd7, ALL_ONES32, 0, ALL_ONES32, 250, 0));
    send_request(OP_MIN,    stamp_pair(8'd0, 0, 0, 0, 0, 0));
    send_request(OP_MAX,    stamp_pair(8'd0, 0, 0, 0, 0, 300000));
    send_request(OP_MAX,    stamp_pair(8'd0, 0, 0, 0, 0, 99999));
    send_request(OP_MAX,    stamp_pair(8'd0, 0, 0, 0, 0, ALL_ONES32));
    send_request(OP_RECORD, stamp_pair(8'd200, 1, 500000, 1, 500123, 0));
    send_request(OP_MIN,    stamp_pair(8'd0, 0, 0, 0, 0, 0));
    send_request(OP_UNUSED, stamp_pair(8'($urandom), $urandom, 20'($urandom), $urandom,
                                       20'($urandom), $urandom));
    send_request(OP_MAX,    stamp_pair(8'd0, 0, 0, 0, 0, 100000));

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_block();
      if (phase < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 63;
      end else if (phase < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0:       set_config(32'd1, 32'd0, 1'b1);
        1:       set_config(ALL_ONES32, 32'd256, 1'b0);
        2:       set_config(32'd0, 32'd511, 1'b0);
        3:       set_config($urandom_range(1000, 300000), $urandom_range(1, 64), 1'b0);
        4:       set_config($urandom_range(1, 5000), $urandom_range(0, 511), 1'b0);
        default: set_config($urandom_range(10000, 1000000), $urandom_range(200, 300), 1'b0);
      endcase
      // long receiver hold-off while requests keep coming
      if (phase == 4) hold_token++;
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        random_request(op, req);
        send_request(op, req);
        if (op != OP_UNUSED) issued++;
      end
    end

    drain_block();
    if (checker_sb.mismatches == 0 && checker_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/wrmm_pkg.sv
hdl/wrmm_alu.sv
hdl/wrmm_store.sv
hdl/wrmm_seq.sv
hdl/windowed_rtt_min_max_store.sv
hdl/wrmm_checker.sv
bench/windowed_rtt_min_max_store_tb.sv
